>>> rtl/lbba_pkg.sv
// ----------------------------------------------------------------------------
// lbba_pkg
// Shared types and constants of the label bounding box accumulator: field
// widths, reserved labels, request codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lbba_pkg;

   localparam int LABEL_W      = 8;
   localparam int PORT_COORD_W = 12;

   localparam logic [LABEL_W-1:0] BG_LABEL   = 8'd0;
   localparam logic [LABEL_W-1:0] SKIP_LABEL = 8'd255;

   localparam logic REQ_ACCUM = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request, read its table entry
      logic commit;      // write back entry, load response if a read
      logic clear_step;  // zero one table entry of the clearing pass
   } lbba_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_read;     // held request is a read
      logic clear_last;  // clearing pass is at its final entry
   } lbba_sts_type;

endpackage

`default_nettype wire

>>> rtl/lbba_ctrl.sv
// ----------------------------------------------------------------------------
// lbba_ctrl
// Controller: clearing pass after reset, request acceptance, execute step
// and response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lbba_ctrl
   import lbba_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output lbba_cmd_type      cmd,
   input  wire lbba_sts_type sts
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cmd.load       = req_valid && req_ready;
   assign cmd.commit     = (state_ff == ST_EXEC) && (!sts.is_read || out_free);
   assign cmd.clear_step = (state_ff == ST_CLEAR);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (sts.clear_last) state_in = ST_IDLE;
         ST_IDLE:  if (cmd.load) state_in = ST_EXEC;
         ST_EXEC:  if (cmd.commit) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      priority if (cmd.commit && sts.is_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lbba_dp.sv
// ----------------------------------------------------------------------------
// lbba_dp
// Datapath: box table memory, request hold registers, min/max update,
// center computation and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lbba_dp
   import lbba_pkg::*;
#(
   parameter int NUM_LABELS = 256,
   parameter int COORD_BITS = 12
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lbba_cmd_type            cmd,
   output lbba_sts_type                 sts,
   input  wire logic                    req_type,
   input  wire logic [LABEL_W-1:0]      req_label,
   input  wire logic [PORT_COORD_W-1:0] req_row,
   input  wire logic [PORT_COORD_W-1:0] req_col,
   output logic [LABEL_W-1:0]           rsp_label_out,
   output logic                         rsp_found,
   output logic [PORT_COORD_W-1:0]      rsp_min_row,
   output logic [PORT_COORD_W-1:0]      rsp_max_row,
   output logic [PORT_COORD_W-1:0]      rsp_min_col,
   output logic [PORT_COORD_W-1:0]      rsp_max_col,
   output logic [PORT_COORD_W-1:0]      rsp_center_row,
   output logic [PORT_COORD_W-1:0]      rsp_center_col
);

   localparam int AW = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
   localparam int CW = COORD_BITS;
   localparam int EW = 1 + 4 * CW;

   // entry layout: {seen, rmin, rmax, cmin, cmax}
   logic [EW-1:0] box_mem [NUM_LABELS];

   logic [AW-1:0]      req_addr;
   logic               req_usable;
   logic [AW-1:0]      clr_idx_ff, clr_idx_in;

   logic               type_ff;
   logic [LABEL_W-1:0] label_ff;
   logic [AW-1:0]      addr_ff;
   logic               usable_ff;
   logic [CW-1:0]      row_ff, col_ff;
   logic [EW-1:0]      entry_ff;

   logic               e_seen;
   logic [CW-1:0]      e_rmin, e_rmax, e_cmin, e_cmax;
   logic [CW-1:0]      n_rmin, n_rmax, n_cmin, n_cmax;
   logic [CW-1:0]      ctr_row, ctr_col;
   logic [EW-1:0]      wr_entry;
   logic               found;

   logic [LABEL_W-1:0]      rsp_label_ff;
   logic                    rsp_found_ff;
   logic [PORT_COORD_W-1:0] rsp_min_row_ff, rsp_max_row_ff;
   logic [PORT_COORD_W-1:0] rsp_min_col_ff, rsp_max_col_ff;
   logic [PORT_COORD_W-1:0] rsp_ctr_row_ff, rsp_ctr_col_ff;

   assign req_addr   = AW'(req_label);
   assign req_usable = (req_label != BG_LABEL) && (req_label != SKIP_LABEL) &&
                       (int'(req_label) < NUM_LABELS);

   assign sts.is_read    = (type_ff == REQ_READ);
   assign sts.clear_last = (clr_idx_ff == AW'(NUM_LABELS - 1));

   // clearing pass index
   assign clr_idx_in = sts.clear_last ? '0 : clr_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_idx_ff <= clr_idx_in;
      end
   end

   // hold request and its table entry
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff   <= req_type;
         label_ff  <= req_label;
         addr_ff   <= req_addr;
         usable_ff <= req_usable;
         row_ff    <= CW'(req_row);
         col_ff    <= CW'(req_col);
         entry_ff  <= box_mem[req_addr];
      end
   end

   assign {e_seen, e_rmin, e_rmax, e_cmin, e_cmax} = entry_ff;

   always_comb begin
      if (!e_seen) begin
         n_rmin = row_ff;
         n_rmax = row_ff;
         n_cmin = col_ff;
         n_cmax = col_ff;
      end else begin
         n_rmin = (row_ff < e_rmin) ? row_ff : e_rmin;
         n_rmax = (row_ff > e_rmax) ? row_ff : e_rmax;
         n_cmin = (col_ff < e_cmin) ? col_ff : e_cmin;
         n_cmax = (col_ff > e_cmax) ? col_ff : e_cmax;
      end
   end

   // a read clears the entry
   assign wr_entry = sts.is_read ? '0 : {1'b1, n_rmin, n_rmax, n_cmin, n_cmax};

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         box_mem[clr_idx_ff] <= '0;
      end else if (cmd.commit && usable_ff) begin
         box_mem[addr_ff] <= wr_entry;
      end
   end

   // max >= min always, so the extent never wraps
   assign ctr_row = e_rmin + ((e_rmax - e_rmin) >> 1);
   assign ctr_col = e_cmin + ((e_cmax - e_cmin) >> 1);
   assign found   = usable_ff && e_seen;

   always_ff @(posedge clock) begin
      if (cmd.commit && sts.is_read) begin
         rsp_label_ff   <= label_ff;
         rsp_found_ff   <= found;
         rsp_min_row_ff <= found ? PORT_COORD_W'(e_rmin)  : '0;
         rsp_max_row_ff <= found ? PORT_COORD_W'(e_rmax)  : '0;
         rsp_min_col_ff <= found ? PORT_COORD_W'(e_cmin)  : '0;
         rsp_max_col_ff <= found ? PORT_COORD_W'(e_cmax)  : '0;
         rsp_ctr_row_ff <= found ? PORT_COORD_W'(ctr_row) : '0;
         rsp_ctr_col_ff <= found ? PORT_COORD_W'(ctr_col) : '0;
      end
   end

   assign rsp_label_out  = rsp_label_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_min_row    = rsp_min_row_ff;
   assign rsp_max_row    = rsp_max_row_ff;
   assign rsp_min_col    = rsp_min_col_ff;
   assign rsp_max_col    = rsp_max_col_ff;
   assign rsp_center_row = rsp_ctr_row_ff;
   assign rsp_center_col = rsp_ctr_col_ff;

endmodule

`default_nettype wire

>>> rtl/label_bounding_box_accumulator_core.sv
// ----------------------------------------------------------------------------
// label_bounding_box_accumulator_core
// Per-label bounding box and center collector over a labelled pixel stream.
// ----------------------------------------------------------------------------
// Each request transaction either accumulates one pixel (req_type 0) into the
// box of its label or reads and clears one label's box (req_type 1); a read
// yields exactly one response transaction, an accumulate yields none. Labels
// 0 and 255, and labels at or above NUM_LABELS, are never stored: a read of
// them reports found 0 with all-zero fields. Every transaction has a capture
// step, which takes it in and reads the label's entry from the single-port box
// table memory, and an execute step, which updates and writes the entry back.
// A new transaction is accepted only after the last one has written back, a
// limit set by that read-modify-write on the table. A read also waits in its
// execute step while an earlier response is still held on the rsp_ port.
// After reset it zeroes the table, one entry per cycle, with req_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module label_bounding_box_accumulator_core
   import lbba_pkg::*;
#(
   parameter int NUM_LABELS = 256,
   parameter int COORD_BITS = 12
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_type,
   input  wire logic [LABEL_W-1:0]      req_label,
   input  wire logic [PORT_COORD_W-1:0] req_row,
   input  wire logic [PORT_COORD_W-1:0] req_col,
   // response channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [LABEL_W-1:0]           rsp_label_out,
   output logic                         rsp_found,
   output logic [PORT_COORD_W-1:0]      rsp_min_row,
   output logic [PORT_COORD_W-1:0]      rsp_max_row,
   output logic [PORT_COORD_W-1:0]      rsp_min_col,
   output logic [PORT_COORD_W-1:0]      rsp_max_col,
   output logic [PORT_COORD_W-1:0]      rsp_center_row,
   output logic [PORT_COORD_W-1:0]      rsp_center_col
);

   lbba_cmd_type cmd;
   lbba_sts_type sts;

   // sequence the clearing pass, accept and execute steps
   lbba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // hold the table and do the box arithmetic
   lbba_dp #(
      .NUM_LABELS (NUM_LABELS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_type       (req_type),
      .req_label      (req_label),
      .req_row        (req_row),
      .req_col        (req_col),
      .rsp_label_out  (rsp_label_out),
      .rsp_found      (rsp_found),
      .rsp_min_row    (rsp_min_row),
      .rsp_max_row    (rsp_max_row),
      .rsp_min_col    (rsp_min_col),
      .rsp_max_col    (rsp_max_col),
      .rsp_center_row (rsp_center_row),
      .rsp_center_col (rsp_center_col)
   );

endmodule

`default_nettype wire

>>> rtl/lbba_checker.sv
// ----------------------------------------------------------------------------
// lbba_checker
// Port-level checks of the accumulator's sequencing and response contents.
// ----------------------------------------------------------------------------
`default_nettype none

module lbba_checker
   import lbba_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    req_type,
   input wire logic                    rsp_valid,
   input wire logic [LABEL_W-1:0]      rsp_label_out,
   input wire logic                    rsp_found,
   input wire logic [PORT_COORD_W-1:0] rsp_min_row,
   input wire logic [PORT_COORD_W-1:0] rsp_max_col,
   input wire logic [PORT_COORD_W-1:0] rsp_center_row
);

   // table clearing holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during table clear");

   // a read into an empty output stage produces a response
   a_read_responds: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_READ && !rsp_valid) |-> ##2 rsp_valid)
      else $error("read produced no response");

   // an accumulate produces no response
   a_accum_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_ACCUM && !rsp_valid) |-> ##2 !rsp_valid)
      else $error("accumulate produced a response");

   // background and wall labels are never found
   a_reserved_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_label_out == BG_LABEL || rsp_label_out == SKIP_LABEL))
      |-> !rsp_found)
      else $error("reserved label reported as found");

   // a miss reports zeros
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
      (rsp_min_row == '0 && rsp_max_col == '0 && rsp_center_row == '0))
      else $error("miss response carries nonzero box");

endmodule

bind label_bounding_box_accumulator_core lbba_checker u_lbba_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_type       (req_type),
   .rsp_valid      (rsp_valid),
   .rsp_label_out  (rsp_label_out),
   .rsp_found      (rsp_found),
   .rsp_min_row    (rsp_min_row),
   .rsp_max_col    (rsp_max_col),
   .rsp_center_row (rsp_center_row)
);

`default_nettype wire

>>> sim/tb_label_bounding_box_accumulator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_label_bounding_box_accumulator_core
// Self-checking bench for the per-label bounding box and center collector.
// ----------------------------------------------------------------------------
// Labelled pixels and read requests go in through the req_ channel. A box
// predictor tracks the per-label extent table next to the block and queues
// the report that every read should return. Each rsp_ transaction is compared
// field by field with the oldest queued report. A short directed pass covers
// the reserved labels, boxes on row and column 0 and on the far edges, read
// after clear and back-to-back updates of one label. A random pass follows,
// built mostly from pixel bursts on a small working set of labels. The sender
// idles in bursts, the receiver stalls on a rotating pattern, and once the
// receiver holds off long enough for the block to back up its input.
// ----------------------------------------------------------------------------

module tb_label_bounding_box_accumulator_core;
   import lbba_pkg::*;

   localparam int TABLE_DEPTH  = 256;
   localparam int RANDOM_ITEMS = 500;
   localparam int HOLD_CYCLES  = 400;

   typedef logic [PORT_COORD_W-1:0] coord_type;
   typedef logic [LABEL_W-1:0]      label_type;

   // one read report as it leaves the rsp_ port
   typedef struct packed {
      label_type label;
      logic      found;
      coord_type min_row;
      coord_type max_row;
      coord_type min_col;
      coord_type max_col;
      coord_type center_row;
      coord_type center_col;
   } box_report_type;

   // -------------------------------------------------------------------------
   // Box predictor and report checker
   // -------------------------------------------------------------------------
   class box_scoreboard;
      bit             seen   [TABLE_DEPTH];
      coord_type      row_lo [TABLE_DEPTH];
      coord_type      row_hi [TABLE_DEPTH];
      coord_type      col_lo [TABLE_DEPTH];
      coord_type      col_hi [TABLE_DEPTH];
      box_report_type pending_reports [$];
      int             mismatches;
      int             reads_checked;
      int             reads_found;
      int             pixels_stored;

      function new();
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            seen[i]   = 1'b0;
            row_lo[i] = '0;
            row_hi[i] = '0;
            col_lo[i] = '0;
            col_hi[i] = '0;
         end
      endfunction

      // Update the table for an accepted request; queue a report for a read.
      function void note_request(logic kind, label_type lab, coord_type r, coord_type c);
         box_report_type rep;
         bit             usable;
         usable = (lab != BG_LABEL) && (lab != SKIP_LABEL) && (int'(lab) < TABLE_DEPTH);
         if (kind == REQ_ACCUM) begin
            if (usable) begin
               pixels_stored++;
               if (!seen[lab]) begin
                  seen[lab]   = 1'b1;
                  row_lo[lab] = r;
                  row_hi[lab] = r;
                  col_lo[lab] = c;
                  col_hi[lab] = c;
               end else begin
                  if (r < row_lo[lab]) row_lo[lab] = r;
                  if (r > row_hi[lab]) row_hi[lab] = r;
                  if (c < col_lo[lab]) col_lo[lab] = c;
                  if (c > col_hi[lab]) col_hi[lab] = c;
               end
            end
         end else begin
            rep       = '0;
            rep.label = lab;
            if (usable && seen[lab]) begin
               rep.found      = 1'b1;
               rep.min_row    = row_lo[lab];
               rep.max_row    = row_hi[lab];
               rep.min_col    = col_lo[lab];
               rep.max_col    = col_hi[lab];
               rep.center_row = row_lo[lab] + ((row_hi[lab] - row_lo[lab]) >> 1);
               rep.center_col = col_lo[lab] + ((col_hi[lab] - col_lo[lab]) >> 1);
            end
            if (usable) begin
               seen[lab]   = 1'b0;
               row_lo[lab] = '0;
               row_hi[lab] = '0;
               col_lo[lab] = '0;
               col_hi[lab] = '0;
            end
            pending_reports.insert(pending_reports.size(), rep);
         end
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t ns] MISMATCH: %s", $time, msg);
      endtask

      task compare_field(string field, label_type lab, logic [31:0] got,
                         logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("label %0d %s got %0d, want %0d",
                                      lab, field, got, want));
      endtask

      // Compare an accepted response against the oldest queued report.
      task check_response(box_report_type got);
         box_report_type want;
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("response for label %0d with no read outstanding",
                                      got.label));
            return;
         end
         want = pending_reports.pop_front();
         reads_checked++;
         if (want.found) reads_found++;
         compare_field("label_out",  want.label, got.label,      want.label);
         compare_field("found",      want.label, got.found,      want.found);
         compare_field("min_row",    want.label, got.min_row,    want.min_row);
         compare_field("max_row",    want.label, got.max_row,    want.max_row);
         compare_field("min_col",    want.label, got.min_col,    want.min_col);
         compare_field("max_col",    want.label, got.max_col,    want.max_col);
         compare_field("center_row", want.label, got.center_row, want.center_row);
         compare_field("center_col", want.label, got.center_col, want.center_col);
      endtask

      function int outstanding();
         return pending_reports.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block ports; every input has a known value from time 0
   // -------------------------------------------------------------------------
   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_type  = REQ_ACCUM;
   label_type req_label = '0;
   coord_type req_row   = '0;
   coord_type req_col   = '0;
   logic      rsp_ready = 1'b0;

   logic      req_ready;
   logic      rsp_valid;
   label_type rsp_label_out;
   logic      rsp_found;
   coord_type rsp_min_row;
   coord_type rsp_max_row;
   coord_type rsp_min_col;
   coord_type rsp_max_col;
   coord_type rsp_center_row;
   coord_type rsp_center_col;

   box_scoreboard sb;

   // handshake with the receiver process: a bump asks for one long hold-off
   int hold_requests = 0;

   // sender burst state
   int burst_left = 0;

   // small working set of labels for well-formed pixel bursts
   label_type active_labels [8];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   label_bounding_box_accumulator_core #(
      .NUM_LABELS (TABLE_DEPTH),
      .COORD_BITS (PORT_COORD_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_label      (req_label),
      .req_row        (req_row),
      .req_col        (req_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_label_out  (rsp_label_out),
      .rsp_found      (rsp_found),
      .rsp_min_row    (rsp_min_row),
      .rsp_max_row    (rsp_max_row),
      .rsp_min_col    (rsp_min_col),
      .rsp_max_col    (rsp_max_col),
      .rsp_center_row (rsp_center_row),
      .rsp_center_col (rsp_center_col)
   );

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the edge, before the block's own updates
   // land. Check the response first; a read accepted at this edge cannot have
   // its answer accepted at the same edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response('{rsp_label_out, rsp_found, rsp_min_row, rsp_max_row,
                                rsp_min_col, rsp_max_col, rsp_center_row,
                                rsp_center_col});
         if (req_valid && req_ready)
            sb.note_request(req_type, req_label, req_row, req_col);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: rotate a 16-bit ready pattern, drawing a fresh one when its age
   // counter runs out, and hold off for HOLD_CYCLES when the stimulus asks for it.
   // -------------------------------------------------------------------------
   initial begin
      logic [15:0] ready_pattern;
      int          pattern_age;
      int          holds_done;
      int          hold_count;
      ready_pattern = 16'hFFFF;
      pattern_age   = 0;
      holds_done    = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            // hold ready low and count the stretch here, not in the sender
            holds_done++;
            rsp_ready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
               @(posedge clock);
         end else begin
            if (pattern_age == 0) begin
               case ($urandom_range(0, 3))
                  0:       ready_pattern = 16'hFFFF;
                  1:       ready_pattern = 16'($urandom);
                  2:       ready_pattern = 16'($urandom) | 16'($urandom);
                  default: ready_pattern = 16'($urandom) & 16'($urandom);
               endcase
               ready_pattern = ready_pattern | 16'h0001;
               pattern_age   = 64;
            end
            pattern_age--;
            rsp_ready     <= ready_pattern[0];
            ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender: offer one transaction, hold it until accepted, then either move
   // straight on or drop valid for a random gap at the end of a burst.
   // -------------------------------------------------------------------------
   task automatic send_request(input logic kind, input label_type lab,
                               input coord_type r, input coord_type c);
      int gap;
      req_valid <= 1'b1;
      req_type  <= kind;
      req_label <= lab;
      req_row   <= r;
      req_col   <= c;
      do @(posedge clock); while (!req_ready);
      if (burst_left == 0) begin
         // long bursts now and then give stretches with no idling at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                           : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   function automatic coord_type pick_coord(int slot);
      // half the pixels cluster per slot, the other half spread over the whole range
      if ($urandom_range(0, 1) == 0)
         return coord_type'($urandom_range(0, 4095));
      return coord_type'(slot * 512 + $urandom_range(0, 63));
   endfunction

   // Mostly pixel bursts and reads on the working set, some reserved labels
   // and some fully random requests. Report whether the item does real work.
   task automatic send_random_item(output bit counts);
      int        pick;
      int        slot;
      label_type lab;
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, 7);
      if ($urandom_range(0, 31) == 0)
         active_labels[slot] = label_type'($urandom_range(1, 254));
      if (pick < 72) begin
         send_request(REQ_ACCUM, active_labels[slot], pick_coord(slot), pick_coord(slot));
         counts = 1'b1;
      end else if (pick < 90) begin
         send_request(REQ_READ, active_labels[slot],
                      coord_type'($urandom), coord_type'($urandom));
         counts = 1'b1;
      end else if (pick < 95) begin
         lab = $urandom_range(0, 1) ? SKIP_LABEL : BG_LABEL;
         send_request(logic'($urandom_range(0, 1)), lab,
                      coord_type'($urandom), coord_type'($urandom));
         counts = (req_type == REQ_READ);
      end else begin
         lab = label_type'($urandom);
         send_request(logic'($urandom_range(0, 1)), lab,
                      coord_type'($urandom), coord_type'($urandom));
         counts = (req_type == REQ_READ) || (lab != BG_LABEL && lab != SKIP_LABEL);
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int random_done;
      bit counts;
      bit pressure_sent;
      random_done   = 0;
      pressure_sent = 1'b0;
      sb = new();
      for (int i = 0; i < 8; i++)
         active_labels[i] = label_type'($urandom_range(1, 254));

      // Reset is asserted once; the block then runs its table clear on its own
      // with req_ready low, which the first transaction simply waits out.
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Unseen label: found 0 and zeros.
      send_request(REQ_READ, 8'd5, 12'd0, 12'd0);
      // A region sitting on row 0 and column 0 must still be reported.
      send_request(REQ_ACCUM, 8'd1, 12'd0, 12'd0);
      send_request(REQ_READ,  8'd1, 12'hFFF, 12'hFFF);
      // Opposite corners on the highest usable label: full-range box.
      send_request(REQ_ACCUM, 8'd254, 12'hFFF, 12'hFFF);
      send_request(REQ_ACCUM, 8'd254, 12'd0, 12'd0);
      send_request(REQ_READ,  8'd254, 12'd0, 12'd0);
      // Background and wall pixels change nothing; reads of them report zeros.
      send_request(REQ_ACCUM, BG_LABEL,   12'd100, 12'd100);
      send_request(REQ_ACCUM, SKIP_LABEL, 12'd200, 12'd200);
      send_request(REQ_READ,  BG_LABEL,   12'd0, 12'd0);
      send_request(REQ_READ,  SKIP_LABEL, 12'd0, 12'd0);
      // Growing box with back-to-back updates of one label, then a read.
      send_request(REQ_ACCUM, 8'd7, 12'd100, 12'd200);
      send_request(REQ_ACCUM, 8'd7, 12'd50,  12'd300);
      send_request(REQ_ACCUM, 8'd7, 12'd150, 12'd250);
      send_request(REQ_ACCUM, 8'd7, 12'd101, 12'd199);
      send_request(REQ_READ,  8'd7, 12'd0, 12'd0);
      // The read cleared the entry: a second read finds nothing.
      send_request(REQ_READ,  8'd7, 12'd0, 12'd0);
      // Odd extents truncate the center; crossing corners on one label.
      send_request(REQ_ACCUM, 8'd2, 12'hFFF, 12'd0);
      send_request(REQ_ACCUM, 8'd2, 12'd0,   12'hFFF);
      send_request(REQ_READ,  8'd2, 12'h5A5, 12'hA5A);
      // Re-seed a cleared label: first pixel sets the box on its own.
      send_request(REQ_ACCUM, 8'd7, 12'd3, 12'd4);
      send_request(REQ_READ,  8'd7, 12'd0, 12'd0);
      // Read directly behind its pixel on a fresh label.
      send_request(REQ_ACCUM, 8'd128, 12'h800, 12'h7FF);
      send_request(REQ_READ,  8'd128, 12'd0, 12'd0);

      // Random traffic. Halfway through, ask the receiver for a long hold-off
      // while the sender keeps offering, so the block backs up its input.
      while (random_done < RANDOM_ITEMS) begin
         send_random_item(counts);
         if (counts) random_done++;
         if (!pressure_sent && random_done >= RANDOM_ITEMS / 2) begin
            hold_requests <= hold_requests + 1;
            pressure_sent  = 1'b1;
         end
      end

      // Sweep every usable label so that the whole predicted table is checked.
      for (int lab = 1; lab < 255; lab++)
         send_request(REQ_READ, label_type'(lab), coord_type'($urandom),
                      coord_type'($urandom));
      req_valid <= 1'b0;

      // Drain, then give stray responses a chance to show up.
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d stored pixels and %0d checked reads, %0d of them with a box,",
               sb.pixels_stored, sb.reads_checked, sb.reads_found);
      $display("with bursty input, stalled output and one %0d-cycle hold-off; %0d mismatches.",
               HOLD_CYCLES, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Watchdog: far beyond the slowest legal run of this stimulus.
   // -------------------------------------------------------------------------
   initial begin
      #(8_000_000);
      $display("Watchdog expired with %0d reads still outstanding", sb.outstanding());
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
rtl/lbba_pkg.sv
rtl/lbba_ctrl.sv
rtl/lbba_dp.sv
rtl/label_bounding_box_accumulator_core.sv
rtl/lbba_checker.sv
sim/tb_label_bounding_box_accumulator_core.sv
